// ===== hdl/rgps_pkg.sv =====
// Shared types and constants for the rotated grid patch sampler.
// Depends on nothing; imported by rgps_axis and the top level.
`default_nettype none

package rgps_pkg;

  // Grid storage
  localparam int MAP_DIM   = 256;
  localparam int MAP_AW    = $clog2(MAP_DIM);
  localparam int DIM_W     = MAP_AW + 1;
  localparam int MAP_CELLS = MAP_DIM * MAP_DIM;
  localparam int COST_W    = 8;

  // Patch geometry
  localparam int PATCH_MAX = 64;
  localparam int PS_W      = 7;
  localparam int SIDX_W    = $clog2(PATCH_MAX);
  localparam int PIDX_W    = 6;

  // Datapath widths
  localparam int START_W     = 24;
  localparam int TRIG_W      = 16;
  localparam int INV_W       = 16;
  localparam int ROT_W       = 25;
  localparam int V_W         = ROT_W - 3;
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int WX_W        = 25;
  localparam int RES_SHIFT   = 18;

  // Configuration port
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_REL_START_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REL_START_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COS_BEARING    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_BEARING    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_RESOLUTION = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PATCH_SIZE     = 3'd7;

  typedef struct packed {
    logic              req_type;
    logic [7:0]        map_x;
    logic [7:0]        map_y;
    logic [COST_W-1:0] cell_cost;
    logic [PIDX_W-1:0] patch_row;
    logic [PIDX_W-1:0] patch_col;
  } req_t;

  typedef struct packed {
    logic [COST_W-1:0] sample_cost;
    logic              inside_grid;
  } rsp_t;

  // Load enables of the per-axis pipeline stages, first to last
  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
    logic e;
    logic f;
    logic g;
  } axis_en_t;

endpackage

`default_nettype wire

// ===== hdl/rgps_axis.sv =====
// One coordinate axis: rotated offset to grid cell index and range check.
// Seven register stages; depends on rgps_pkg.
`default_nettype none

module rgps_axis
  import rgps_pkg::*;
(
  input  logic                      clk,
  input  axis_en_t                  en,
  input  logic signed [ROT_W-1:0]   rot,
  input  logic signed [START_W-1:0] start,
  input  logic [RECIP_W-1:0]        recip,
  input  logic [PS_W-1:0]           side_len,
  input  logic [INV_W-1:0]          inv_res,
  input  logic [DIM_W-1:0]          lim,
  output logic                      hit,
  output logic [MAP_AW-1:0]         idx
);

  localparam int PB_W = V_W + RECIP_W;
  localparam int QS_W = V_W + PS_W;
  localparam int PM_W = WX_W + INV_W + 1;
  localparam int MX_W = PM_W - RES_SHIFT;
  localparam logic [PM_W-1:0] RND = PM_W'((1 << RES_SHIFT) - 1);

  // stage a: sign and magnitude
  logic             neg_a;
  logic [ROT_W-1:0] mag_a;
  // stage b: reciprocal product
  logic             neg_b;
  logic             lnz_b;
  logic [V_W-1:0]   v_b;
  logic [PB_W-1:0]  pm_b;
  // stage c: quotient and remainder flag
  logic             neg_c;
  logic             rnz_c;
  logic [V_W-1:0]   q_c;
  // stage d: floored sum
  logic                    rnz_d;
  logic signed [WX_W-1:0]  t_d;
  // stage e: truncated metres
  logic signed [WX_W-1:0]  wx_e;
  // stage f: scaled to cells
  logic signed [PM_W-1:0]  pm_f;

  logic [ROT_W-1:0]       mag_next;
  logic [V_W-1:0]         qe;
  logic [QS_W-1:0]        qs;
  logic [WX_W-1:0]        q_ext;
  logic [WX_W-1:0]        t_next;
  logic [WX_W-1:0]        wx_next;
  logic signed [PM_W-1:0] pm_next;
  logic [PM_W-1:0]        mx_sum;
  logic [MX_W-1:0]        mx;
  logic                   hit_next;

  assign mag_next = rot[ROT_W-1] ? ROT_W'(-rot) : ROT_W'(rot);

  // quotient is exact for every magnitude: v * (m*s - 2^K) < 2^K
  assign qe = pm_b[RECIP_SHIFT +: V_W];
  assign qs = QS_W'(qe) * QS_W'(side_len);

  // floor(r / 8s) added to start; negative r gives ~q + (remainder zero)
  assign q_ext  = WX_W'(q_c);
  assign t_next = WX_W'(start) + (neg_c ? ~q_ext : q_ext) + WX_W'(neg_c & ~rnz_c);

  // truncation toward zero: a negative floored result with a remainder steps up
  assign wx_next = t_d + WX_W'(t_d[WX_W-1] & rnz_d);

  assign pm_next = PM_W'(wx_e) * PM_W'($signed({1'b0, inv_res}));

  assign mx_sum = pm_f + (pm_f[PM_W-1] ? RND : '0);
  assign mx     = mx_sum[PM_W-1:RES_SHIFT];

  assign hit_next = !mx[MX_W-1] && (mx[MX_W-2:DIM_W] == '0) && (mx[DIM_W-1:0] < lim);

  always_ff @(posedge clk) begin
    if (en.a) begin
      neg_a <= rot[ROT_W-1];
      mag_a <= mag_next;
    end
    if (en.b) begin
      neg_b <= neg_a;
      lnz_b <= |mag_a[2:0];
      v_b   <= mag_a[ROT_W-1:3];
      pm_b  <= PB_W'(mag_a[ROT_W-1:3]) * PB_W'(recip);
    end
    if (en.c) begin
      neg_c <= neg_b;
      rnz_c <= lnz_b | (QS_W'(v_b) != qs);
      q_c   <= qe;
    end
    if (en.d) begin
      rnz_d <= rnz_c;
      t_d   <= $signed(t_next);
    end
    if (en.e) begin
      wx_e <= $signed(wx_next);
    end
    if (en.f) begin
      pm_f <= pm_next;
    end
    if (en.g) begin
      hit <= hit_next;
      idx <= mx[MAP_AW-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rotated_grid_patch_sampler_top.sv =====
// Rotated grid patch sampler: config registers, item pipeline and cost grid RAM.
// Depends on rgps_pkg and rgps_axis.
//
// Usage
//   req channel (req_valid / req_stall / req) carries one beat per item.
//   req_type 0 writes cell_cost into the grid at (map_x, map_y) and gives
//   no result. req_type 1 samples patch cell (patch_row, patch_col): the
//   cell centre is rotated by the bearing, offset from the start point,
//   scaled to grid cells (truncated toward zero) and looked up.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns one beat per sample
//   with the stored cost, or cost 0 and inside_grid 0 off the grid.
//   cfg port: cfg_we, cfg_index, cfg_data; write only while idle.
// Timing
//   rsp_valid rises for a taken beat once it has passed the input, rotation,
//   per-axis and grid RAM stages. One item per cycle sustained while rsp
//   is not stalled; the single-port grid RAM takes one read or one write a
//   cycle, in item order, so a write is seen by every later sample.
//   A stalled rsp holds its beat; req_stall rises only once every stage
//   holds an item, so bubbles are squeezed out before the input stops.
// Reset
//   Synchronous rst empties the pipeline and loads the register defaults.
//   The grid is not cleared: a cell reads as undefined until written.
`default_nettype none

module rotated_grid_patch_sampler_top
  import rgps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int NST = 10;

  typedef struct packed {
    logic              is_sample;
    logic              free;
    logic [7:0]        map_x;
    logic [7:0]        map_y;
    logic [COST_W-1:0] cell_cost;
  } side_t;

  // configuration registers
  logic signed [START_W-1:0] rel_start_x;
  logic signed [START_W-1:0] rel_start_y;
  logic signed [TRIG_W-1:0]  cos_bearing;
  logic signed [TRIG_W-1:0]  sin_bearing;
  logic [INV_W-1:0]          inv_resolution;
  logic [DIM_W-1:0]          map_width;
  logic [DIM_W-1:0]          map_height;
  logic [PS_W-1:0]           patch_size;

  logic [PS_W-1:0]    s_eff;
  logic [SIDX_W-1:0]  s_idx;
  logic [RECIP_W-1:0] recip;
  logic [DIM_W-1:0]   w_lim;
  logic [DIM_W-1:0]   h_lim;

  logic [NST:1] vld;
  logic [NST:1] rdy;
  side_t        side_q [NST:1];
  side_t        side_in;

  logic [PIDX_W-1:0] row1;
  logic [PIDX_W-1:0] col1;

  logic signed [7:0]       fwd_k;
  logic signed [8:0]       lat_k;
  logic signed [ROT_W:0]   rx_full;
  logic signed [ROT_W:0]   ry_full;
  logic signed [ROT_W-1:0] rot_x;
  logic signed [ROT_W-1:0] rot_y;

  axis_en_t           ax_en;
  logic               hx;
  logic               hy;
  logic [MAP_AW-1:0]  ix;
  logic [MAP_AW-1:0]  iy;

  logic                  hit9;
  logic                  wr_ok;
  logic                  mem_we;
  logic [2*MAP_AW-1:0]   mem_addr;
  logic [COST_W-1:0]     cost_mem [MAP_CELLS];
  logic [COST_W-1:0]     rd_data;
  logic                  hit10;

  logic [RECIP_W-1:0] recip_tab [PATCH_MAX];

  // ceil(2^K / s) for each patch side
  for (genvar g = 0; g < PATCH_MAX; g++) begin : g_recip
    localparam longint unsigned RV = ((longint'(1) << RECIP_SHIFT) + g) / (g + 1);
    assign recip_tab[g] = RECIP_W'(RV);
  end

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      rel_start_x    <= '0;
      rel_start_y    <= '0;
      cos_bearing    <= TRIG_W'(16384);
      sin_bearing    <= '0;
      inv_resolution <= INV_W'(2560);
      map_width      <= '0;
      map_height     <= '0;
      patch_size     <= PS_W'(32);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REL_START_X:    rel_start_x    <= $signed(cfg_data[START_W-1:0]);
        REG_REL_START_Y:    rel_start_y    <= $signed(cfg_data[START_W-1:0]);
        REG_COS_BEARING:    cos_bearing    <= $signed(cfg_data[TRIG_W-1:0]);
        REG_SIN_BEARING:    sin_bearing    <= $signed(cfg_data[TRIG_W-1:0]);
        REG_INV_RESOLUTION: inv_resolution <= cfg_data[INV_W-1:0];
        REG_MAP_WIDTH:      map_width      <= cfg_data[DIM_W-1:0];
        REG_MAP_HEIGHT:     map_height     <= cfg_data[DIM_W-1:0];
        REG_PATCH_SIZE:     patch_size     <= cfg_data[PS_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_eff = (patch_size == '0)               ? PS_W'(1) :
                 (patch_size > PS_W'(PATCH_MAX))  ? PS_W'(PATCH_MAX) : patch_size;
  assign s_idx = SIDX_W'(s_eff - PS_W'(1));
  assign recip = recip_tab[s_idx];
  assign w_lim = (map_width  > DIM_W'(MAP_DIM)) ? DIM_W'(MAP_DIM) : map_width;
  assign h_lim = (map_height > DIM_W'(MAP_DIM)) ? DIM_W'(MAP_DIM) : map_height;

  // ---------------------------------------------------------- flow control
  always_comb begin
    rdy[NST] = !vld[NST] || !side_q[NST].is_sample || !rsp_stall;
    for (int k = NST - 1; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign req_stall = !rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) vld[1] <= req_valid;
      for (int k = 2; k <= NST; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // ------------------------------------------------------- stage 1: input
  always_comb begin
    side_in.is_sample = req.req_type;
    side_in.free      = (w_lim == '0) || (h_lim == '0) || (inv_resolution == '0) ||
                        (PS_W'(req.patch_row) >= s_eff) || (PS_W'(req.patch_col) >= s_eff);
    side_in.map_x     = req.map_x;
    side_in.map_y     = req.map_y;
    side_in.cell_cost = req.cell_cost;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      side_q[1] <= side_in;
      row1      <= req.patch_row;
      col1      <= req.patch_col;
    end
    for (int k = 2; k <= NST; k++) begin
      if (rdy[k]) side_q[k] <= side_q[k-1];
    end
  end

  // ---------------------------------------------------- stage 2: rotation
  // Patch scale and the Q14 factor cancel: offsets are (2row+1) forward and
  // (2col+1-s) lateral over a common denominator of 8s.
  assign fwd_k   = $signed({1'b0, row1, 1'b1});
  assign lat_k   = $signed({2'b00, col1, 1'b1}) - $signed({2'b00, s_eff});
  assign rx_full = fwd_k * cos_bearing - lat_k * sin_bearing;
  assign ry_full = fwd_k * sin_bearing + lat_k * cos_bearing;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      rot_x <= rx_full[ROT_W-1:0];
      rot_y <= ry_full[ROT_W-1:0];
    end
  end

  // ------------------------------------------------ stages 3..9: per axis
  assign ax_en = '{a: rdy[3], b: rdy[4], c: rdy[5], d: rdy[6], e: rdy[7], f: rdy[8],
                   g: rdy[9]};

  rgps_axis u_axis_x (
    .clk      (clk),
    .en       (ax_en),
    .rot      (rot_x),
    .start    (rel_start_x),
    .recip    (recip),
    .side_len (s_eff),
    .inv_res  (inv_resolution),
    .lim      (w_lim),
    .hit      (hx),
    .idx      (ix)
  );

  rgps_axis u_axis_y (
    .clk      (clk),
    .en       (ax_en),
    .rot      (rot_y),
    .start    (rel_start_y),
    .recip    (recip),
    .side_len (s_eff),
    .inv_res  (inv_resolution),
    .lim      (h_lim),
    .hit      (hy),
    .idx      (iy)
  );

  // ------------------------------------------------- stage 10: grid RAM
  // One access a cycle in item order while not stalled, so no same-entry overlap can occur.
  assign hit9     = hx & hy & !side_q[NST-1].free;
  assign wr_ok    = (DIM_W'(side_q[NST-1].map_x) < DIM_W'(MAP_DIM)) &&
                    (DIM_W'(side_q[NST-1].map_y) < DIM_W'(MAP_DIM));
  assign mem_addr = side_q[NST-1].is_sample ? {iy, ix} :
                    {MAP_AW'(side_q[NST-1].map_y), MAP_AW'(side_q[NST-1].map_x)};
  assign mem_we   = rdy[NST] && vld[NST-1] && !side_q[NST-1].is_sample && wr_ok;

  always_ff @(posedge clk) begin
    if (rdy[NST]) begin
      if (mem_we) cost_mem[mem_addr] <= side_q[NST-1].cell_cost;
      rd_data <= cost_mem[mem_addr];
      hit10   <= hit9;
    end
  end

  assign rsp_valid       = vld[NST] && side_q[NST].is_sample;
  assign rsp.sample_cost = hit10 ? rd_data : '0;
  assign rsp.inside_grid = hit10;

`ifndef SYNTHESIS
  a_reset_empty : assert property (@(posedge clk) (!rst && $past(rst)) |-> (vld == '0))
    else $error("pipeline not empty after reset");

  a_stall_full : assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (&vld))
    else $error("input stalled with a bubble in the pipeline");

  a_hit_bounds : assert property (@(posedge clk) disable iff (rst)
    (vld[NST-1] && side_q[NST-1].is_sample && hit9) |->
      ((DIM_W'(ix) < w_lim) && (DIM_W'(iy) < h_lim)))
    else $error("grid hit outside configured size");

  a_side_range : assert property (@(posedge clk) disable iff (rst)
    (s_eff != '0) && (s_eff <= PS_W'(PATCH_MAX)))
    else $error("effective patch side out of range");
`endif

endmodule

`default_nettype wire

// ===== sim/rotated_grid_patch_sampler_top_tb.sv =====
// Self-checking testbench for rotated_grid_patch_sampler_top: grid writes and
// rotated patch samples checked against a local predictor. Needs rgps_pkg and the RTL.
`timescale 1ns / 1ps

module rotated_grid_patch_sampler_top_tb;
  import rgps_pkg::*;

  localparam longint AXIAL_STEP   = 4096;
  localparam longint LATERAL_HALF = 2048;
  localparam int     SETTLE       = 16;
  localparam int     RANDOM_ITEMS = 400;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req       = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_REL_START_X;
  logic [CFG_W-1:0]     cfg_data  = '0;

  rotated_grid_patch_sampler_top dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow of the block's registers, at reset values
  logic signed [START_W-1:0] start_x_q = '0;
  logic signed [START_W-1:0] start_y_q = '0;
  logic signed [TRIG_W-1:0]  cos_q     = 16'sd16384;
  logic signed [TRIG_W-1:0]  sin_q     = '0;
  logic [INV_W-1:0]          inv_res_q = 16'd2560;
  logic [DIM_W-1:0]          width_q   = '0;
  logic [DIM_W-1:0]          height_q  = '0;
  logic [PS_W-1:0]           psize_q   = 7'd32;

  logic [COST_W-1:0] grid_q [MAP_CELLS];
  bit                grid_written [MAP_CELLS];

  rsp_t pending_costs [$];
  int   mismatches = 0;
  int   items_sent = 0;
  bit   tx_calm    = 1'b0;
  bit   rx_calm    = 1'b0;
  int   stall_left = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // World position (1/1024 m) truncated, then scaled to cells, truncated again
  function automatic longint to_grid(input longint start, input longint rot,
                                     input longint den);
    longint pos;
    pos = (start * 16384 * den + rot) / (16384 * den);
    return (pos * longint'(inv_res_q)) / 262144;
  endfunction

  // Returns 1 and the grid address when the sample lands on the grid
  function automatic bit locate_cell(input req_t item, output int spot);
    longint side, row, col, den, ax, ay, c, s, gx, gy, w, h;
    spot = 0;
    side = psize_q;
    if (side < 1) side = 1;
    if (side > PATCH_MAX) side = PATCH_MAX;
    row = item.patch_row;
    col = item.patch_col;
    w = (width_q > MAP_DIM) ? MAP_DIM : width_q;
    h = (height_q > MAP_DIM) ? MAP_DIM : height_q;
    if (w == 0 || h == 0 || inv_res_q == 0 || row >= side || col >= side) return 1'b0;
    den = 2 * side;
    ax = AXIAL_STEP * (2 * row + 1);
    ay = 2 * LATERAL_HALF * (2 * col + 1 - side);
    c = cos_q;
    s = sin_q;
    gx = to_grid(start_x_q, ax * c - ay * s, den);
    gy = to_grid(start_y_q, ax * s + ay * c, den);
    if (gx < 0 || gy < 0 || gx >= w || gy >= h) return 1'b0;
    spot = int'(gy * MAP_DIM + gx);
    return 1'b1;
  endfunction

  function automatic rsp_t predict_sample(input req_t item);
    rsp_t r;
    int   spot;
    r = '0;
    if (locate_cell(item, spot)) begin
      r.sample_cost = grid_q[spot];
      r.inside_grid = 1'b1;
    end
    return r;
  endfunction

  function automatic longint pick4(input longint a, input longint b,
                                   input longint c, input longint d);
    case ($urandom_range(0, 3))
      0: return a;
      1: return b;
      2: return c;
      default: return d;
    endcase
  endfunction

  // Sends one beat; valid stays high on return so a back-to-back beat can follow
  task automatic push_request(input req_t item);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (req_stall);
    items_sent++;
    if (item.req_type) begin
      pending_costs = {pending_costs, predict_sample(item)};
    end else begin
      grid_q[int'(item.map_y) * MAP_DIM + item.map_x] = item.cell_cost;
      grid_written[int'(item.map_y) * MAP_DIM + item.map_x] = 1'b1;
    end
  endtask

  task automatic store_cell(input int x, input int y, input int cost);
    req_t item;
    item.req_type  = 1'b0;
    item.map_x     = 8'(x);
    item.map_y     = 8'(y);
    item.cell_cost = COST_W'(cost);
    item.patch_row = PIDX_W'($urandom_range(0, 63));
    item.patch_col = PIDX_W'($urandom_range(0, 63));
    push_request(item);
  endtask

  // Fills the target grid entry first if it has never been written
  task automatic sample_patch(input int row, input int col);
    req_t item;
    int   spot;
    item.req_type  = 1'b1;
    item.map_x     = 8'($urandom_range(0, 255));
    item.map_y     = 8'($urandom_range(0, 255));
    item.cell_cost = COST_W'($urandom_range(0, 255));
    item.patch_row = PIDX_W'(row);
    item.patch_col = PIDX_W'(col);
    if (locate_cell(item, spot) && !grid_written[spot])
      store_cell(spot % MAP_DIM, spot / MAP_DIM, $urandom_range(0, 255));
    push_request(item);
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (pending_costs.size() != 0) @(posedge clk);
    // writes give no result and may still be in the pipe
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic set_phase(input longint sx, input longint sy, input longint c,
                           input longint s, input longint inv, input longint w,
                           input longint h, input longint ps);
    wait_idle();
    cfg_write(REG_REL_START_X, sx[CFG_W-1:0]);
    cfg_write(REG_REL_START_Y, sy[CFG_W-1:0]);
    cfg_write(REG_COS_BEARING, c[CFG_W-1:0]);
    cfg_write(REG_SIN_BEARING, s[CFG_W-1:0]);
    cfg_write(REG_INV_RESOLUTION, inv[CFG_W-1:0]);
    cfg_write(REG_MAP_WIDTH, w[CFG_W-1:0]);
    cfg_write(REG_MAP_HEIGHT, h[CFG_W-1:0]);
    cfg_write(REG_PATCH_SIZE, ps[CFG_W-1:0]);
    cfg_we <= 1'b0;
    start_x_q = sx[START_W-1:0];
    start_y_q = sy[START_W-1:0];
    cos_q     = c[TRIG_W-1:0];
    sin_q     = s[TRIG_W-1:0];
    inv_res_q = inv[INV_W-1:0];
    width_q   = w[DIM_W-1:0];
    height_q  = h[DIM_W-1:0];
    psize_q   = ps[PS_W-1:0];
    @(posedge clk);
  endtask

  // Receiver: after each beat, hold stall for a drawn number of cycles
  always @(posedge clk) begin : rsp_pacing
    int draw;
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left <= 0;
    end else if (rsp_valid && !rsp_stall) begin
      draw = rx_calm ? 0 : $urandom_range(0, 13);
      stall_left <= draw;
      rsp_stall <= (draw != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_costs.size() == 0) begin
        $display("%0t: unexpected beat: cost %0d inside %0b", $time,
                 rsp.sample_cost, rsp.inside_grid);
        mismatches++;
      end else begin
        want = pending_costs.pop_front();
        if (rsp.sample_cost !== want.sample_cost) begin
          $display("%0t: sample_cost expected %0d got %0d", $time,
                   want.sample_cost, rsp.sample_cost);
          mismatches++;
        end
        if (rsp.inside_grid !== want.inside_grid) begin
          $display("%0t: inside_grid expected %0b got %0b", $time,
                   want.inside_grid, rsp.inside_grid);
          mismatches++;
        end
      end
    end
  end

  // Map size 0 out of reset: every sample is free
  task automatic test_reset_defaults();
    sample_patch(0, 0);
    sample_patch(31, 31);
    store_cell(0, 0, 255);
    store_cell(255, 255, 0);
  endtask

  task automatic test_aligned_patch();
    set_phase(13107, 13107, 16384, 0, 2560, 256, 256, 32);
    sample_patch(0, 0);
    sample_patch(31, 31);
    sample_patch(0, 31);
    sample_patch(32, 5);
    sample_patch(5, 63);
  endtask

  task automatic test_edge_settings();
    // slightly negative world position truncates to cell 0
    set_phase(-100, -100, 16384, 0, 2560, 256, 256, 32);
    sample_patch(0, 16);
    sample_patch(0, 0);
    // patch size 0 acts as 1; oversize map clamps to storage
    set_phase(13107, 13107, -16384, 16384, 2560, 300, 511, 0);
    sample_patch(0, 0);
    sample_patch(1, 0);
    // oversize patch, start at the register extremes
    set_phase(8388607, -8388608, 16384, -16384, 65535, 256, 1, 127);
    sample_patch(63, 63);
    sample_patch(0, 0);
    set_phase(1000, 1000, 11585, 11585, 1, 511, 256, 64);
    sample_patch(0, 0);
    sample_patch(63, 0);
    set_phase(13107, 13107, 16384, 0, 0, 256, 256, 64);
    sample_patch(0, 0);
    set_phase(13107, 13107, 0, -16384, 2560, 256, 0, 16);
    sample_patch(3, 3);
  endtask

  task automatic test_random_patches();
    int     goal, phase, batch, side, kind;
    longint w, h, inv, span, sx, sy, c, s, ps;
    goal = items_sent + RANDOM_ITEMS;
    phase = 0;
    while (items_sent < goal) begin
      if (phase % 5 == 4) begin
        w   = pick4(0, 1, 256, 511);
        h   = pick4(0, 1, 256, 511);
        inv = pick4(0, 1, 65535, 2560);
        ps  = pick4(0, 1, 64, 127);
        c   = pick4(-16384, 16384, 0, 16384);
        s   = pick4(-16384, 16384, 0, -16384);
        sx  = pick4(-8388608, 8388607, 0, $urandom_range(0, 26214));
        sy  = pick4(-8388608, 8388607, 0, $urandom_range(0, 26214));
      end else begin
        w   = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 256);
        h   = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 256);
        inv = $urandom_range(256, 8000);
        span = (w * 262144) / inv;
        sx  = longint'($urandom_range(0, span)) - $urandom_range(0, 2048);
        span = (h * 262144) / inv;
        sy  = longint'($urandom_range(0, span)) - $urandom_range(0, 2048);
        if ($urandom_range(0, 2) == 0) begin
          c = pick4(16384, 0, -16384, 11585);
          s = pick4(16384, 0, -16384, -11585);
        end else begin
          c = longint'($urandom_range(0, 32768)) - 16384;
          s = longint'($urandom_range(0, 32768)) - 16384;
        end
        ps = ($urandom_range(0, 7) == 0) ? pick4(0, 65, 100, 127) : $urandom_range(1, 64);
      end
      set_phase(sx, sy, c, s, inv, w, h, ps);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      side = (ps < 1) ? 1 : (ps > PATCH_MAX) ? PATCH_MAX : int'(ps);
      batch = $urandom_range(20, 50);
      repeat (batch) begin
        kind = $urandom_range(0, 19);
        if (kind < 2)
          store_cell($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        else if (kind < 4)
          sample_patch($urandom_range(0, 63), $urandom_range(0, 63));
        else
          sample_patch($urandom_range(0, side - 1), $urandom_range(0, side - 1));
      end
      phase++;
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_aligned_patch();
    test_edge_settings();
    test_random_patches();
    wait_idle();
    if (mismatches == 0 && pending_costs.size() == 0) begin
      $display("** rotated_grid_patch_sampler_top: PASSED **");
    end else begin
      $display("** rotated_grid_patch_sampler_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** rotated_grid_patch_sampler_top: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rgps_pkg.sv
hdl/rgps_axis.sv
hdl/rotated_grid_patch_sampler_top.sv
sim/rotated_grid_patch_sampler_top_tb.sv
